// File: hdl/dual_side_pid_drive_tick_unit_macros.svh
// Assertion macros for the dual side PID drive tick unit checker.
`ifndef DUAL_SIDE_PID_DRIVE_TICK_UNIT_MACROS_SVH
`define DUAL_SIDE_PID_DRIVE_TICK_UNIT_MACROS_SVH

// Check cons in the same cycle as ante.
`define PDT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pdt check failed");

// Check cons in the cycle after ante.
`define PDT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pdt check failed");

`endif

// File: hdl/pdt_pkg.sv
// Shared types, widths and constants of the dual side PID drive tick unit.
`timescale 1ns / 1ps
package pdt_pkg;

	localparam int CNT_W    = 24;
	localparam int TGT_W    = 23;
	localparam int GAIN_W   = 16;
	localparam int LIM_W    = 14;
	localparam int DIR_W    = 2;
	localparam int ERR_W    = 25;
	localparam int DIF_W    = 26;
	localparam int INT_W    = 32;
	localparam int MUL_A_W  = 33;
	localparam int PROD_W   = MUL_A_W + GAIN_W + 1;
	localparam int ACC_W    = 56;
	localparam int PID_W    = 38;
	localparam int PID_LO_W = 19;
	localparam int PWR_W    = 44;
	localparam int RAT_W    = PWR_W + 4;
	localparam int DRV_W    = 15;
	localparam int SLW_W    = DRV_W + 2;
	localparam int SET_W    = ERR_W + 1;
	localparam int DWELL_W  = 16;
	localparam int Q_FRAC   = 12;

	localparam int IN_W     = 3 * CNT_W;
	localparam int OUT_W    = 32;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	localparam int INTEGRAL_ZONE = 100;
	localparam int SETTLE_WINDOW = 30;
	localparam int DWELL_TICKS   = 0;

	localparam logic signed [ERR_W-1:0] ZONE_E     = ERR_W'(INTEGRAL_ZONE);
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (Q_FRAC - 1));

	localparam logic [TGT_W-1:0]  RST_TARGET = '0;
	localparam logic [GAIN_W-1:0] RST_GAIN_P = 16'd2048;
	localparam logic [GAIN_W-1:0] RST_GAIN_I = 16'd82;
	localparam logic [GAIN_W-1:0] RST_GAIN_D = 16'd4096;
	localparam logic [GAIN_W-1:0] RST_SCALE  = 16'd4096;
	localparam logic [LIM_W-1:0]  RST_LIMIT  = 14'd12000;
	localparam logic [LIM_W-1:0]  RST_STEP   = 14'd240;
	localparam logic [DIR_W-1:0]  RST_DIR    = 2'b01;

	typedef enum logic [2:0] {
		REG_TARGET = 3'd0,
		REG_GAIN_P = 3'd1,
		REG_GAIN_I = 3'd2,
		REG_GAIN_D = 3'd3,
		REG_SCALE  = 3'd4,
		REG_LIMIT  = 3'd5,
		REG_STEP   = 3'd6,
		REG_DIR    = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CALC = 4'b0010,
		S_EQU  = 4'b0100,
		S_LIM  = 4'b1000
	} tick_state_t;

	typedef struct packed {
		logic go;
		logic clr;
	} lane_ctl_t;

	typedef struct packed {
		logic clr;
		logic eq_en;
		logic lim_en;
	} merge_ctl_t;

endpackage

// File: hdl/pdt_lane.sv
// One side's PID lane: error, integral, and a shared multiply-accumulate sequence.
`timescale 1ns / 1ps
module pdt_lane (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pdt_pkg::lane_ctl_t                    ctl,
	input  logic signed [pdt_pkg::CNT_W-1:0]      count,
	input  logic        [pdt_pkg::TGT_W-1:0]      target_counts,
	input  logic        [pdt_pkg::GAIN_W-1:0]     gain_p,
	input  logic        [pdt_pkg::GAIN_W-1:0]     gain_i,
	input  logic        [pdt_pkg::GAIN_W-1:0]     gain_d,
	input  logic        [pdt_pkg::GAIN_W-1:0]     output_scale,
	output logic                                  done,
	output logic signed [pdt_pkg::PWR_W-1:0]      power
);
	import pdt_pkg::*;

	typedef enum logic [9:0] {
		L_IDLE   = 10'b0000000001,
		L_MUL_P  = 10'b0000000010,
		L_MUL_I  = 10'b0000000100,
		L_MUL_D  = 10'b0000001000,
		L_SUM_D  = 10'b0000010000,
		L_PID    = 10'b0000100000,
		L_MUL_LO = 10'b0001000000,
		L_MUL_HI = 10'b0010000000,
		L_SUM_HI = 10'b0100000000,
		L_POWER  = 10'b1000000000
	} lane_state_t;

	lane_state_t                  st_q;
	logic                         done_q;
	logic signed [INT_W-1:0]      integ_q;
	logic signed [ERR_W-1:0]      prev_q;
	logic signed [ERR_W-1:0]      err_q;
	logic signed [DIF_W-1:0]      diff_q;
	logic signed [ACC_W-1:0]      acc_q;
	logic signed [PID_W-1:0]      pid_q;
	logic signed [PWR_W-1:0]      power_q;
	logic signed [PROD_W-1:0]     prod_s1;

	logic signed [ERR_W-1:0]      cnt_ext;
	logic signed [ERR_W-1:0]      cnt_mag;
	logic signed [ERR_W-1:0]      err_new;
	logic signed [INT_W-1:0]      integ_base;
	logic signed [ERR_W-1:0]      prev_base;
	logic signed [MUL_A_W-1:0]    integ_sum;
	logic signed [INT_W-1:0]      integ_new;
	logic signed [DIF_W-1:0]      diff_new;
	logic signed [MUL_A_W-1:0]    mul_a;
	logic        [GAIN_W-1:0]     mul_b;
	logic signed [PROD_W-1:0]     prod_full;
	logic signed [PID_W-PID_LO_W-1:0] pid_hi;
	logic signed [ACC_W-1:0]      addend;
	logic signed [ACC_W-1:0]      acc_rnd;
	logic signed [ACC_W-1:0]      rnd_shift;

	always_comb begin
		cnt_ext    = ERR_W'(count);
		cnt_mag    = cnt_ext[ERR_W-1] ? -cnt_ext : cnt_ext;
		err_new    = $signed({2'b00, target_counts}) - cnt_mag;
		integ_base = ctl.clr ? '0 : integ_q;
		prev_base  = ctl.clr ? '0 : prev_q;
		integ_sum  = MUL_A_W'(integ_base) + MUL_A_W'(err_new);
		if (err_new < ZONE_E) begin
			if (integ_sum[MUL_A_W-1] != integ_sum[MUL_A_W-2]) begin
				integ_new = integ_sum[MUL_A_W-1] ? {1'b1, {(INT_W-1){1'b0}}}
					: {1'b0, {(INT_W-1){1'b1}}};
			end else begin
				integ_new = integ_sum[INT_W-1:0];
			end
		end else begin
			integ_new = '0;
		end
		diff_new = DIF_W'(err_new) - DIF_W'(prev_base);
	end

	always_comb begin
		pid_hi = $signed(pid_q[PID_W-1:PID_LO_W]);
		case (st_q)
			L_MUL_P: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = gain_p;
			end
			L_MUL_I: begin
				mul_a = MUL_A_W'(integ_q);
				mul_b = gain_i;
			end
			L_MUL_D: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = gain_d;
			end
			L_MUL_LO: begin
				mul_a = $signed(MUL_A_W'(pid_q[PID_LO_W-1:0]));
				mul_b = output_scale;
			end
			L_MUL_HI: begin
				mul_a = MUL_A_W'(pid_hi);
				mul_b = output_scale;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod_full = mul_a * $signed({1'b0, mul_b});
		addend    = (st_q == L_SUM_HI) ? (ACC_W'(prod_s1) <<< PID_LO_W) : ACC_W'(prod_s1);
		acc_rnd   = acc_q + ROUND_HALF;
		rnd_shift = acc_rnd >>> Q_FRAC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= L_IDLE;
			done_q  <= 1'b0;
			integ_q <= '0;
			prev_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				L_IDLE: begin
					if (ctl.go) begin
						integ_q <= integ_new;
						prev_q  <= err_new;
						st_q    <= L_MUL_P;
					end
				end
				L_MUL_P:  st_q <= L_MUL_I;
				L_MUL_I:  st_q <= L_MUL_D;
				L_MUL_D:  st_q <= L_SUM_D;
				L_SUM_D:  st_q <= L_PID;
				L_PID:    st_q <= L_MUL_LO;
				L_MUL_LO: st_q <= L_MUL_HI;
				L_MUL_HI: st_q <= L_SUM_HI;
				L_SUM_HI: st_q <= L_POWER;
				L_POWER: begin
					done_q <= 1'b1;
					st_q   <= L_IDLE;
				end
				default:  st_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_full;
		case (st_q)
			L_IDLE: begin
				if (ctl.go) begin
					err_q  <= err_new;
					diff_q <= diff_new;
					acc_q  <= '0;
				end
			end
			L_MUL_I, L_MUL_D, L_SUM_D, L_MUL_HI, L_SUM_HI: begin
				acc_q <= acc_q + addend;
			end
			L_PID: begin
				pid_q <= rnd_shift[PID_W-1:0];
				acc_q <= '0;
			end
			L_POWER: begin
				power_q <= rnd_shift[PWR_W-1:0];
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign done  = done_q;
	assign power = power_q;

endmodule

// File: hdl/pdt_merge.sv
// Merge stage: side equalizing, symmetric clamp, slew limit and direction.
`timescale 1ns / 1ps
module pdt_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pdt_pkg::merge_ctl_t               ctl,
	input  logic signed [pdt_pkg::PWR_W-1:0]  power_l,
	input  logic signed [pdt_pkg::PWR_W-1:0]  power_r,
	input  logic        [pdt_pkg::LIM_W-1:0]  power_limit,
	input  logic        [pdt_pkg::LIM_W-1:0]  max_step,
	input  logic        [pdt_pkg::DIR_W-1:0]  drive_direction,
	output logic signed [pdt_pkg::DRV_W-1:0]  drive_l,
	output logic signed [pdt_pkg::DRV_W-1:0]  drive_r
);
	import pdt_pkg::*;

	function automatic logic ratio_over(input logic signed [PWR_W-1:0] a,
		input logic signed [PWR_W-1:0] b);
		logic signed [RAT_W-1:0] a10;
		logic signed [RAT_W-1:0] b11;
		logic                    res;
		a10 = (RAT_W'(a) <<< 3) + (RAT_W'(a) <<< 1);
		b11 = (RAT_W'(b) <<< 3) + (RAT_W'(b) <<< 1) + RAT_W'(b);
		if (b > 0) begin
			res = a10 > b11;
		end else if (b < 0) begin
			res = a10 < b11;
		end else begin
			res = a > 0;
		end
		return res;
	endfunction

	function automatic logic signed [DRV_W-1:0] clamp_slew(
		input logic signed [PWR_W-1:0] p,
		input logic signed [DRV_W-1:0] prev,
		input logic        [LIM_W-1:0] lim,
		input logic        [LIM_W-1:0] stp);
		logic signed [PWR_W-1:0] lim_e;
		logic signed [PWR_W-1:0] cl;
		logic signed [SLW_W-1:0] cl_n;
		logic signed [SLW_W-1:0] prev_e;
		logic signed [SLW_W-1:0] stp_e;
		logic signed [SLW_W-1:0] res;
		lim_e = $signed(PWR_W'(lim));
		if (p > lim_e) begin
			cl = lim_e;
		end else if (p < -lim_e) begin
			cl = -lim_e;
		end else begin
			cl = p;
		end
		cl_n   = cl[SLW_W-1:0];
		prev_e = SLW_W'(prev);
		stp_e  = $signed(SLW_W'(stp));
		if (cl_n - prev_e > stp_e) begin
			res = prev_e + stp_e;
		end else if (prev_e - cl_n > stp_e) begin
			res = prev_e - stp_e;
		end else begin
			res = cl_n;
		end
		return res[DRV_W-1:0];
	endfunction

	logic signed [PWR_W-1:0] eq_l_s1;
	logic signed [PWR_W-1:0] eq_r_s1;
	logic signed [PWR_W-1:0] eq_l;
	logic signed [PWR_W-1:0] eq_r;
	logic signed [DRV_W-1:0] prev_l_q;
	logic signed [DRV_W-1:0] prev_r_q;
	logic signed [DRV_W-1:0] lim_l;
	logic signed [DRV_W-1:0] lim_r;
	logic                    dir_neg;
	logic                    dir_zero;

	always_comb begin
		if (ratio_over(power_l, power_r)) begin
			eq_l = power_l;
			eq_r = power_l;
		end else if (ratio_over(power_r, power_l)) begin
			eq_l = power_r;
			eq_r = power_r;
		end else begin
			eq_l = power_l;
			eq_r = power_r;
		end
		lim_l    = clamp_slew(eq_l_s1, prev_l_q, power_limit, max_step);
		lim_r    = clamp_slew(eq_r_s1, prev_r_q, power_limit, max_step);
		dir_neg  = drive_direction[DIR_W-1];
		dir_zero = (drive_direction == '0);
		drive_l  = dir_neg ? -lim_l : (dir_zero ? '0 : lim_l);
		drive_r  = dir_neg ? -lim_r : (dir_zero ? '0 : lim_r);
	end

	always_ff @(posedge clk) begin
		if (ctl.eq_en) begin
			eq_l_s1 <= eq_l;
			eq_r_s1 <= eq_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q <= '0;
			prev_r_q <= '0;
		end else if (ctl.clr) begin
			prev_l_q <= '0;
			prev_r_q <= '0;
		end else if (ctl.lim_en) begin
			prev_l_q <= lim_l;
			prev_r_q <= lim_r;
		end
	end

endmodule

// File: hdl/dual_side_pid_drive_tick_unit.sv
// Top level of the dual side PID drive tick unit: registers, sequencing, settle logic.
`timescale 1ns / 1ps
// One control tick per input beat. Two PID lanes, one per wheel, run side by
// side; each walks its terms through its own multiplier in a nine-step
// multiply-accumulate sequence, and a two-step merge then equalizes the sides,
// clamps to +-power_limit, slew-limits and applies drive_direction. The next
// beat is taken only once the result sits in the output register, so a new
// tick never starts before the last one is through; a stalled output holds
// the result, and with it the next beat, back. start_move in tuser clears all
// integral, previous error, previous drive and settle state before that tick
// is worked. settled is the settle test of the same tick and is not latched.
module dual_side_pid_drive_tick_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pdt_pkg::IN_W-1:0]      s_tdata,   // left_count, right_count, average_count
	input  logic                          s_tuser,   // start_move
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pdt_pkg::OUT_W-1:0]     m_tdata,   // left_drive, right_drive, settled, pad
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pdt_pkg::ADDR_W-1:0]    paddr,
	input  logic [pdt_pkg::DATA_W-1:0]    pwdata,
	output logic [pdt_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import pdt_pkg::*;

	logic [TGT_W-1:0]  target_q;
	logic [GAIN_W-1:0] gain_p_q;
	logic [GAIN_W-1:0] gain_i_q;
	logic [GAIN_W-1:0] gain_d_q;
	logic [GAIN_W-1:0] scale_q;
	logic [LIM_W-1:0]  limit_q;
	logic [LIM_W-1:0]  step_q;
	logic [DIR_W-1:0]  dir_q;

	tick_state_t       state_q;
	logic              win_q;
	logic [DWELL_W-1:0] dwell_q;
	logic              settled_q;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	logic              accept;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;
	lane_ctl_t         lane_ctl;
	merge_ctl_t        merge_ctl;
	logic              done_l;
	logic              done_r;
	logic signed [PWR_W-1:0] power_l;
	logic signed [PWR_W-1:0] power_r;
	logic signed [DRV_W-1:0] drive_l;
	logic signed [DRV_W-1:0] drive_r;
	logic              out_free;

	logic signed [CNT_W-1:0] left_count;
	logic signed [CNT_W-1:0] right_count;
	logic signed [CNT_W-1:0] average_count;
	logic signed [ERR_W-1:0] avg_ext;
	logic        [ERR_W-1:0] avg_mag;
	logic signed [SET_W-1:0] ac_s;
	logic signed [SET_W-1:0] win_lo;
	logic signed [SET_W-1:0] win_hi;
	logic              in_lo;
	logic              in_hi;
	logic              win_base;
	logic [DWELL_W-1:0] dwell_base;
	logic              win_n;
	logic [DWELL_W-1:0] dwell_n;
	logic              done_n;

	assign left_count    = $signed(s_tdata[CNT_W-1:0]);
	assign right_count   = $signed(s_tdata[2*CNT_W-1:CNT_W]);
	assign average_count = $signed(s_tdata[3*CNT_W-1:2*CNT_W]);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= RST_TARGET;
			gain_p_q <= RST_GAIN_P;
			gain_i_q <= RST_GAIN_I;
			gain_d_q <= RST_GAIN_D;
			scale_q  <= RST_SCALE;
			limit_q  <= RST_LIMIT;
			step_q   <= RST_STEP;
			dir_q    <= RST_DIR;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_TARGET: target_q <= pwdata[TGT_W-1:0];
				REG_GAIN_P: gain_p_q <= pwdata[GAIN_W-1:0];
				REG_GAIN_I: gain_i_q <= pwdata[GAIN_W-1:0];
				REG_GAIN_D: gain_d_q <= pwdata[GAIN_W-1:0];
				REG_SCALE:  scale_q  <= pwdata[GAIN_W-1:0];
				REG_LIMIT:  limit_q  <= pwdata[LIM_W-1:0];
				REG_STEP:   step_q   <= pwdata[LIM_W-1:0];
				REG_DIR:    dir_q    <= pwdata[DIR_W-1:0];
				default:    target_q <= target_q;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_TARGET: prdata = DATA_W'(target_q);
			REG_GAIN_P: prdata = DATA_W'(gain_p_q);
			REG_GAIN_I: prdata = DATA_W'(gain_i_q);
			REG_GAIN_D: prdata = DATA_W'(gain_d_q);
			REG_SCALE:  prdata = DATA_W'(scale_q);
			REG_LIMIT:  prdata = DATA_W'(limit_q);
			REG_STEP:   prdata = DATA_W'(step_q);
			REG_DIR:    prdata = {{(DATA_W-DIR_W){dir_q[DIR_W-1]}}, dir_q};
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		avg_ext    = ERR_W'(average_count);
		avg_mag    = avg_ext[ERR_W-1] ? ERR_W'(-avg_ext) : ERR_W'(avg_ext);
		ac_s       = $signed(SET_W'(avg_mag));
		win_lo     = $signed(SET_W'(target_q)) - SET_W'(SETTLE_WINDOW);
		win_hi     = $signed(SET_W'(target_q)) + SET_W'(SETTLE_WINDOW);
		in_lo      = ac_s > win_lo;
		in_hi      = ac_s < win_hi;
		win_base   = s_tuser ? 1'b0 : win_q;
		dwell_base = s_tuser ? '0 : dwell_q;
		done_n     = 1'b0;
		if (win_base) begin
			win_n   = 1'b1;
			dwell_n = (&dwell_base) ? dwell_base : dwell_base + 1'b1;
		end else if (in_lo) begin
			win_n   = 1'b1;
			dwell_n = '0;
		end else begin
			win_n   = 1'b0;
			dwell_n = dwell_base;
		end
		if (win_n && (dwell_n > DWELL_W'(DWELL_TICKS))) begin
			if (in_lo && in_hi) begin
				done_n = 1'b1;
			end else begin
				dwell_n = '0;
			end
		end
	end

	always_comb begin
		lane_ctl.go      = accept;
		lane_ctl.clr     = s_tuser;
		merge_ctl.clr    = accept && s_tuser;
		merge_ctl.eq_en  = (state_q == S_CALC) && done_l && done_r;
		merge_ctl.lim_en = (state_q == S_EQU) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			win_q      <= 1'b0;
			dwell_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						win_q   <= win_n;
						dwell_q <= dwell_n;
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					if (done_l && done_r) begin
						state_q <= S_EQU;
					end
				end
				S_EQU: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_LIM:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			settled_q <= done_n;
		end
		if (merge_ctl.lim_en) begin
			m_tdata_q <= {{(OUT_W-2*DRV_W-1){1'b0}}, settled_q, drive_r, drive_l};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	pdt_lane u_lane_l (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (lane_ctl),
		.count         (left_count),
		.target_counts (target_q),
		.gain_p        (gain_p_q),
		.gain_i        (gain_i_q),
		.gain_d        (gain_d_q),
		.output_scale  (scale_q),
		.done          (done_l),
		.power         (power_l)
	);

	pdt_lane u_lane_r (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (lane_ctl),
		.count         (right_count),
		.target_counts (target_q),
		.gain_p        (gain_p_q),
		.gain_i        (gain_i_q),
		.gain_d        (gain_d_q),
		.output_scale  (scale_q),
		.done          (done_r),
		.power         (power_r)
	);

	pdt_merge u_merge (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (merge_ctl),
		.power_l         (power_l),
		.power_r         (power_r),
		.power_limit     (limit_q),
		.max_step        (step_q),
		.drive_direction (dir_q),
		.drive_l         (drive_l),
		.drive_r         (drive_r)
	);

endmodule

// File: hdl/pdt_checker.sv
// Port-level checker for the dual side PID drive tick unit, with its bind.
`timescale 1ns / 1ps
`include "dual_side_pid_drive_tick_unit_macros.svh"
module pdt_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [pdt_pkg::OUT_W-1:0] m_tdata
);
	import pdt_pkg::*;

	localparam logic [DRV_W-1:0] DRV_MIN = {1'b1, {(DRV_W-1){1'b0}}};

	logic drv_ok;

	assign drv_ok = (m_tdata[DRV_W-1:0] != DRV_MIN) && (m_tdata[2*DRV_W-1:DRV_W] != DRV_MIN)
		&& !m_tdata[OUT_W-1];

	`PDT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`PDT_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
	`PDT_ASSERT_NEXT(a_one_tick, s_tvalid && s_tready, !s_tready)
	`PDT_ASSERT_NOW(a_drive_range, m_tvalid, drv_ok)

endmodule

bind dual_side_pid_drive_tick_unit pdt_checker u_pdt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
